FILE: rtl/core/gcfr_pkg.sv
// Package for the grid cell flow redistribution core.
// Holds side indices, open-sides codes, the sideband struct and the open mask table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gcfr_pkg;

    localparam int FLOW_FRAC_BITS_DEF = 16;
    localparam int FLOW_INT_BITS_DEF  = 8;

    // side indices
    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    // open-sides codes
    localparam logic [3:0] CODE_ALL_OPEN     = 4'd0;
    localparam logic [3:0] CODE_TOP_SHUT     = 4'd1;
    localparam logic [3:0] CODE_RIGHT_SHUT   = 4'd2;
    localparam logic [3:0] CODE_BOTTOM_SHUT  = 4'd3;
    localparam logic [3:0] CODE_LEFT_SHUT    = 4'd4;
    localparam logic [3:0] CODE_BOTTOM_LEFT  = 4'd5;
    localparam logic [3:0] CODE_RIGHT_LEFT   = 4'd6;
    localparam logic [3:0] CODE_RIGHT_BOTTOM = 4'd7;
    localparam logic [3:0] CODE_TOP_LEFT     = 4'd8;
    localparam logic [3:0] CODE_TOP_BOTTOM   = 4'd9;
    localparam logic [3:0] CODE_TOP_RIGHT    = 4'd10;
    localparam logic [3:0] CODE_LEFT_ONLY    = 4'd11;
    localparam logic [3:0] CODE_TOP_ONLY     = 4'd12;
    localparam logic [3:0] CODE_RIGHT_ONLY   = 4'd13;
    localparam logic [3:0] CODE_BOTTOM_ONLY  = 4'd14;
    localparam logic [3:0] CODE_ALL_SHUT     = 4'd15;

    typedef struct packed {
        logic [3:0] code;
        logic       xpos;
        logic       xneg;
        logic       ypos;
        logic       yneg;
        logic       sumpos;
        logic       uniform;
    } t_side;

    // bit0 top, bit1 right, bit2 bottom, bit3 left
    function automatic logic [3:0] open_mask(input logic [3:0] code);
        logic [3:0] m;
        case (code)
            CODE_ALL_OPEN:     m = 4'b1111;
            CODE_TOP_SHUT:     m = 4'b1110;
            CODE_RIGHT_SHUT:   m = 4'b1101;
            CODE_BOTTOM_SHUT:  m = 4'b1011;
            CODE_LEFT_SHUT:    m = 4'b0111;
            CODE_BOTTOM_LEFT:  m = 4'b1100;
            CODE_RIGHT_LEFT:   m = 4'b1010;
            CODE_RIGHT_BOTTOM: m = 4'b0110;
            CODE_TOP_LEFT:     m = 4'b1001;
            CODE_TOP_BOTTOM:   m = 4'b0101;
            CODE_TOP_RIGHT:    m = 4'b0011;
            CODE_LEFT_ONLY:    m = 4'b1000;
            CODE_TOP_ONLY:     m = 4'b0001;
            CODE_RIGHT_ONLY:   m = 4'b0010;
            CODE_BOTTOM_ONLY:  m = 4'b0100;
            default:           m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gcfr_front.sv
// Front stages: input capture, totals and differences, then the products.
// Depends on gcfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcfr_front
    import gcfr_pkg::*;
#(
    parameter int IN_BITS = FLOW_INT_BITS_DEF + FLOW_FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [IN_BITS-1:0]         i_top,
    input  wire logic [IN_BITS-1:0]         i_right,
    input  wire logic [IN_BITS-1:0]         i_bottom,
    input  wire logic [IN_BITS-1:0]         i_left,
    input  wire logic [3:0]                 i_code,
    input  wire logic [7:0]                 i_tol,
    output logic                            o_valid,
    output logic [2*IN_BITS+1:0]            o_prod,
    output logic [IN_BITS:0]                o_sum,
    output logic [IN_BITS+1:0]              o_total,
    output logic [IN_BITS+1:0]              o_third,
    output t_side                           o_side
);
    localparam int W  = IN_BITS + 2;
    localparam int K  = W + 2;
    localparam logic [K-1:0] RECIP3 = K'(((64'd1 << K) + 64'd2) / 64'd3);

    // stage 1
    logic               r1_valid;
    logic [IN_BITS-1:0] r1_t, r1_r, r1_b, r1_l;
    logic [3:0]         r1_code;

    // stage 2
    logic               r2_valid;
    logic [W-1:0]       r2_total;
    logic [IN_BITS-1:0] r2_ax;
    logic [IN_BITS:0]   r2_s;
    t_side              r2_side;

    logic signed [IN_BITS:0]   xd, yd;
    logic signed [IN_BITS+1:0] sum_d;
    logic [IN_BITS:0]          axw, ayw;
    logic [IN_BITS-1:0]        ax, ay;
    t_side                     n_side;
    logic [W+K-1:0]            third_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_t    <= i_top;
        r1_r    <= i_right;
        r1_b    <= i_bottom;
        r1_l    <= i_left;
        r1_code <= i_code;
    end

    always_comb begin
        xd    = $signed({1'b0, r1_l}) - $signed({1'b0, r1_r});
        yd    = $signed({1'b0, r1_b}) - $signed({1'b0, r1_t});
        sum_d = (IN_BITS+2)'(xd) + (IN_BITS+2)'(yd);
        axw   = xd[IN_BITS] ? (IN_BITS+1)'(-xd) : (IN_BITS+1)'(xd);
        ayw   = yd[IN_BITS] ? (IN_BITS+1)'(-yd) : (IN_BITS+1)'(yd);
        ax    = axw[IN_BITS-1:0];
        ay    = ayw[IN_BITS-1:0];
        n_side.code    = r1_code;
        n_side.xpos    = (xd > 0);
        n_side.xneg    = xd[IN_BITS];
        n_side.ypos    = (yd > 0);
        n_side.yneg    = yd[IN_BITS];
        n_side.sumpos  = (sum_d > 0);
        n_side.uniform = ((ax < IN_BITS'(i_tol)) && (ay < IN_BITS'(i_tol)))
                         || ((ax == '0) && (ay == '0));
    end

    always_ff @(posedge i_clk) begin
        r2_total <= W'(r1_t) + W'(r1_r) + W'(r1_b) + W'(r1_l);
        r2_ax    <= ax;
        r2_s     <= (IN_BITS+1)'(ax) + (IN_BITS+1)'(ay);
        r2_side  <= n_side;
    end

    // stage 3: total*|xd| for the axis split, total*recip for a third
    assign third_full = (W+K)'(r2_total) * (W+K)'(RECIP3);

    always_ff @(posedge i_clk) begin
        o_prod  <= (2*IN_BITS+2)'(r2_total) * (2*IN_BITS+2)'(r2_ax);
        o_third <= third_full[W+K-1:K];
        o_sum   <= r2_s;
        o_total <= r2_total;
        o_side  <= r2_side;
    end
endmodule
`default_nettype wire

FILE: rtl/core/gcfr_div.sv
// Pipelined restoring divider, one quotient bit per stage; carries sideband.
// Depends on gcfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcfr_div
    import gcfr_pkg::*;
#(
    parameter int IN_BITS = FLOW_INT_BITS_DEF + FLOW_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [2*IN_BITS+1:0]  i_prod,
    input  wire logic [IN_BITS:0]      i_sum,
    input  wire logic [IN_BITS+1:0]    i_total,
    input  wire logic [IN_BITS+1:0]    i_third,
    input  wire t_side                 i_side,
    output logic                       o_valid,
    output logic [IN_BITS+1:0]         o_quot,
    output logic                       o_rem_nz,
    output logic [IN_BITS+1:0]         o_total,
    output logic [IN_BITS+1:0]         o_third,
    output t_side                      o_side
);
    localparam int W = IN_BITS + 2;

    logic               r_valid [W+1];
    logic [IN_BITS:0]   r_rem   [W+1];
    logic [W-1:0]       r_low   [W+1];
    logic [IN_BITS:0]   r_sum   [W+1];
    logic [W-1:0]       r_total [W+1];
    logic [W-1:0]       r_third [W+1];
    t_side              r_side  [W+1];

    always_comb begin
        r_valid[0] = i_valid;
        r_rem[0]   = {1'b0, i_prod[2*IN_BITS+1:W]};
        r_low[0]   = i_prod[W-1:0];
        r_sum[0]   = i_sum;
        r_total[0] = i_total;
        r_third[0] = i_third;
        r_side[0]  = i_side;
    end

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic [IN_BITS+1:0] trial;
        logic               ge;
        assign trial = {r_rem[g], r_low[g][W-1]};
        assign ge    = (trial >= (IN_BITS+2)'(r_sum[g]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else begin
                r_valid[g+1] <= r_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]   <= ge ? (IN_BITS+1)'(trial - (IN_BITS+2)'(r_sum[g]))
                               : trial[IN_BITS:0];
            r_low[g+1]   <= {r_low[g][W-2:0], ge};
            r_sum[g+1]   <= r_sum[g];
            r_total[g+1] <= r_total[g];
            r_third[g+1] <= r_third[g];
            r_side[g+1]  <= r_side[g];
        end
    end

    assign o_valid  = r_valid[W];
    assign o_quot   = r_low[W];
    assign o_rem_nz = (r_rem[W] != '0);
    assign o_total  = r_total[W];
    assign o_third  = r_third[W];
    assign o_side   = r_side[W];
endmodule
`default_nettype wire

FILE: rtl/core/gcfr_route.sv
// Output stage: uniform share or axis split, steered onto the open sides.
// Depends on gcfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcfr_route
    import gcfr_pkg::*;
#(
    parameter int IN_BITS = FLOW_INT_BITS_DEF + FLOW_FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [IN_BITS+1:0]  i_quot,
    input  wire logic                i_rem_nz,
    input  wire logic [IN_BITS+1:0]  i_total,
    input  wire logic [IN_BITS+1:0]  i_third,
    input  wire t_side               i_side,
    output logic                     o_valid,
    output logic [IN_BITS+1:0]       o_flow [4]
);
    localparam int W = IN_BITS + 2;

    logic [W-1:0] xf, yf, share;
    logic [3:0]   mask;
    logic [1:0]   xt, yt;
    logic [W-1:0] n_flow [4];

    always_comb begin
        mask = open_mask(i_side.code);
        xf   = i_quot;
        // floor(total*|yd|/s) = total - ceil(total*|xd|/s)
        yf   = i_total - i_quot - W'(i_rem_nz);
        case ($countones(mask))
            4:       share = i_total >> 2;
            3:       share = i_third;
            2:       share = i_total >> 1;
            default: share = i_total;
        endcase

        xt = i_side.xpos ? SIDE_RIGHT : SIDE_LEFT;
        yt = i_side.ypos ? SIDE_TOP : SIDE_BOTTOM;
        case (i_side.code)
            CODE_ALL_OPEN:     ;
            CODE_TOP_SHUT:     yt = SIDE_BOTTOM;
            CODE_RIGHT_SHUT:   xt = SIDE_LEFT;
            CODE_BOTTOM_SHUT:  yt = (i_side.ypos || i_side.yneg) ? SIDE_TOP : SIDE_BOTTOM;
            CODE_LEFT_SHUT:    xt = (i_side.xpos || i_side.xneg) ? SIDE_RIGHT : SIDE_LEFT;
            CODE_BOTTOM_LEFT: begin
                xt = i_side.xpos ? SIDE_BOTTOM : SIDE_LEFT;
                yt = i_side.ypos ? SIDE_LEFT : SIDE_BOTTOM;
            end
            CODE_RIGHT_LEFT: begin
                xt = i_side.sumpos ? SIDE_RIGHT : SIDE_LEFT;
                yt = xt;
            end
            CODE_RIGHT_BOTTOM: begin
                xt = i_side.xneg ? SIDE_BOTTOM : SIDE_RIGHT;
                yt = i_side.ypos ? SIDE_RIGHT : SIDE_BOTTOM;
            end
            CODE_TOP_LEFT: begin
                xt = i_side.xpos ? SIDE_TOP : SIDE_LEFT;
                yt = i_side.yneg ? SIDE_LEFT : SIDE_TOP;
            end
            CODE_TOP_BOTTOM: begin
                xt = i_side.sumpos ? SIDE_TOP : SIDE_BOTTOM;
                yt = xt;
            end
            CODE_TOP_RIGHT: begin
                xt = i_side.xneg ? SIDE_TOP : SIDE_RIGHT;
                yt = i_side.yneg ? SIDE_RIGHT : SIDE_TOP;
            end
            CODE_LEFT_ONLY: begin
                xt = SIDE_LEFT;
                yt = SIDE_LEFT;
            end
            CODE_TOP_ONLY: begin
                xt = SIDE_TOP;
                yt = SIDE_TOP;
            end
            CODE_RIGHT_ONLY: begin
                xt = SIDE_RIGHT;
                yt = SIDE_RIGHT;
            end
            default: begin
                xt = SIDE_BOTTOM;
                yt = SIDE_BOTTOM;
            end
        endcase

        for (int k = 0; k < 4; k++) begin
            if (i_side.code == CODE_ALL_SHUT) begin
                n_flow[k] = '0;
            end else if (i_side.uniform) begin
                n_flow[k] = mask[k] ? share : '0;
            end else begin
                n_flow[k] = ((xt == 2'(k)) ? xf : '0) + ((yt == 2'(k)) ? yf : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            o_flow[k] <= n_flow[k];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/grid_cell_flow_redistribution_core.sv
// Grid cell flow redistribution core: top level.
// Pipeline from start to o_done: the front stages, the divider stages, then the registered output stage.
// Throughput: one cell per cycle; busy stays low, the pipeline has no stalls.
// Depth is set by the divider, one quotient bit per stage over the output width.
// Reset (synchronous, active low) empties the pipeline and sets the tolerance to 1.
// Depends on gcfr_pkg, gcfr_front, gcfr_div, gcfr_route.
`timescale 1ns / 1ps
`default_nettype none
module grid_cell_flow_redistribution_core
    import gcfr_pkg::*;
#(
    parameter int FLOW_FRAC_BITS = FLOW_FRAC_BITS_DEF,
    parameter int FLOW_INT_BITS  = FLOW_INT_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [FLOW_INT_BITS+FLOW_FRAC_BITS-1:0] i_inflow_top,
    input  wire logic [FLOW_INT_BITS+FLOW_FRAC_BITS-1:0] i_inflow_right,
    input  wire logic [FLOW_INT_BITS+FLOW_FRAC_BITS-1:0] i_inflow_bottom,
    input  wire logic [FLOW_INT_BITS+FLOW_FRAC_BITS-1:0] i_inflow_left,
    input  wire logic [3:0]                             i_open_sides_code,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [7:0]                             i_cfg_data,
    output logic                                        o_done,
    output logic [FLOW_INT_BITS+FLOW_FRAC_BITS+1:0]     o_outflow_top,
    output logic [FLOW_INT_BITS+FLOW_FRAC_BITS+1:0]     o_outflow_right,
    output logic [FLOW_INT_BITS+FLOW_FRAC_BITS+1:0]     o_outflow_bottom,
    output logic [FLOW_INT_BITS+FLOW_FRAC_BITS+1:0]     o_outflow_left
);
    localparam int IN_BITS = FLOW_INT_BITS + FLOW_FRAC_BITS;
    localparam int W       = IN_BITS + 2;

    // tolerance register; the user must write it only when no transaction is in flight, the block does not enforce it
    logic [7:0] r_tol;

    logic              f_valid;
    logic [2*IN_BITS+1:0] f_prod;
    logic [IN_BITS:0]  f_sum;
    logic [W-1:0]      f_total, f_third;
    t_side             f_side;

    logic              d_valid, d_rem_nz;
    logic [W-1:0]      d_quot, d_total, d_third;
    t_side             d_side;

    logic [W-1:0]      flow [4];

    // fully pipelined: a new cell may enter every cycle
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    // stages 1-3: capture, totals/differences, products
    gcfr_front #(.IN_BITS(IN_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_top    (i_inflow_top),
        .i_right  (i_inflow_right),
        .i_bottom (i_inflow_bottom),
        .i_left   (i_inflow_left),
        .i_code   (i_open_sides_code),
        .i_tol    (r_tol),
        .o_valid  (f_valid),
        .o_prod   (f_prod),
        .o_sum    (f_sum),
        .o_total  (f_total),
        .o_third  (f_third),
        .o_side   (f_side)
    );

    // x share = floor(total*|xd| / (|xd|+|yd|)), one bit per stage
    gcfr_div #(.IN_BITS(IN_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .i_prod   (f_prod),
        .i_sum    (f_sum),
        .i_total  (f_total),
        .i_third  (f_third),
        .i_side   (f_side),
        .o_valid  (d_valid),
        .o_quot   (d_quot),
        .o_rem_nz (d_rem_nz),
        .o_total  (d_total),
        .o_third  (d_third),
        .o_side   (d_side)
    );

    // steering onto open sides, registered outputs
    gcfr_route #(.IN_BITS(IN_BITS)) u_route (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d_valid),
        .i_quot   (d_quot),
        .i_rem_nz (d_rem_nz),
        .i_total  (d_total),
        .i_third  (d_third),
        .i_side   (d_side),
        .o_valid  (o_done),
        .o_flow   (flow)
    );

    assign o_outflow_top    = flow[SIDE_TOP];
    assign o_outflow_right  = flow[SIDE_RIGHT];
    assign o_outflow_bottom = flow[SIDE_BOTTOM];
    assign o_outflow_left   = flow[SIDE_LEFT];
endmodule
`default_nettype wire

FILE: rtl/core/gcfr_chk.sv
// Port-level checker for the flow redistribution core, bound to the top level.
// Depends on gcfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcfr_chk
    import gcfr_pkg::*;
#(
    parameter int IN_BITS = FLOW_INT_BITS_DEF + FLOW_FRAC_BITS_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [3:0]         i_open_sides_code,
    input wire logic               o_cfg_ready,
    input wire logic               o_done,
    input wire logic [IN_BITS+1:0] o_outflow_top,
    input wire logic [IN_BITS+1:0] o_outflow_right,
    input wire logic [IN_BITS+1:0] o_outflow_bottom,
    input wire logic [IN_BITS+1:0] o_outflow_left
);
    localparam int LAT = IN_BITS + 6;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] r_cnt;
    logic          warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_cnt != CW'(LAT)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end
    assign warm = (r_cnt == CW'(LAT));

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (warm && $past(start && !busy, LAT)) |-> o_done)
        else $error("accepted transaction not delivered on time");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (warm && o_done) |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    a_closed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (warm && o_done && $past(i_open_sides_code == CODE_ALL_SHUT, LAT))
        |-> (o_outflow_top == '0 && o_outflow_right == '0 &&
             o_outflow_bottom == '0 && o_outflow_left == '0))
        else $error("flow sent from a fully closed cell");

    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("core stalled");
endmodule

bind grid_cell_flow_redistribution_core gcfr_chk #(
    .IN_BITS(FLOW_INT_BITS + FLOW_FRAC_BITS)
) u_gcfr_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_open_sides_code (i_open_sides_code),
    .o_cfg_ready       (o_cfg_ready),
    .o_done            (o_done),
    .o_outflow_top     (o_outflow_top),
    .o_outflow_right   (o_outflow_right),
    .o_outflow_bottom  (o_outflow_bottom),
    .o_outflow_left    (o_outflow_left)
);
`default_nettype wire

FILE: dv/testbench.sv
// Testbench for the grid cell flow redistribution core.
// Drives cells through start/busy and checks every o_done result against an in-bench predictor.
// Depends on gcfr_pkg and grid_cell_flow_redistribution_core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import gcfr_pkg::*;

    localparam int IW = FLOW_INT_BITS_DEF + FLOW_FRAC_BITS_DEF;
    localparam int OW = IW + 2;
    localparam int LATENCY = IW + 6;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [IW-1:0] top;
        logic [IW-1:0] right;
        logic [IW-1:0] bottom;
        logic [IW-1:0] left;
        logic [3:0]    code;
    } t_cell;

    typedef struct packed {
        logic [OW-1:0] top;
        logic [OW-1:0] right;
        logic [OW-1:0] bottom;
        logic [OW-1:0] left;
    } t_outflow;

    // Pending work for the driver: either a cell or a tolerance write.
    typedef struct packed {
        logic       is_cfg;
        logic       drain;      // wait until nothing is outstanding first
        logic [7:0] tol;
        t_cell      item;
    } t_job;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [IW-1:0] inflow_top = '0, inflow_right = '0, inflow_bottom = '0, inflow_left = '0;
    logic [3:0] open_code = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;
    logic o_done;
    logic [OW-1:0] out_top, out_right, out_bottom, out_left;

    grid_cell_flow_redistribution_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_inflow_top(inflow_top), .i_inflow_right(inflow_right),
        .i_inflow_bottom(inflow_bottom), .i_inflow_left(inflow_left),
        .i_open_sides_code(open_code),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_done(o_done),
        .o_outflow_top(out_top), .o_outflow_right(out_right),
        .o_outflow_bottom(out_bottom), .o_outflow_left(out_left)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_job     job_q[$];
    t_outflow expected_flows[$];
    logic [7:0] model_tol = 8'd1;   // tolerance as the predictor sees it
    int mismatches = 0;
    int cells_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int cycles = 0;
    bit stim_done = 1'b0;
    bit code_hit[16];

    // Predicted outflows for one cell under the tolerance in force.
    function automatic t_outflow redistribute(t_cell c, logic [7:0] tol);
        logic [63:0] total, ax, ay, sum, xf, yf, share;
        logic [63:0] o[4];
        logic signed [63:0] xd, yd, xs, ys;
        logic [3:0] m;
        int n;
        t_outflow r;
        total = 64'(c.top) + 64'(c.right) + 64'(c.bottom) + 64'(c.left);
        xd = $signed(64'(c.left)) - $signed(64'(c.right));
        yd = $signed(64'(c.bottom)) - $signed(64'(c.top));
        ax = xd < 0 ? -xd : xd;
        ay = yd < 0 ? -yd : yd;
        for (int k = 0; k < 4; k++) o[k] = '0;
        if (c.code != CODE_ALL_SHUT) begin
            if ((ax < tol && ay < tol) || (ax == 0 && ay == 0)) begin
                m = open_mask(c.code);
                n = m[0] + m[1] + m[2] + m[3];
                share = total / n;
                for (int k = 0; k < 4; k++) if (m[k]) o[k] = share;
            end else begin
                // Products stay under 2^60, so plain division truncates exactly.
                sum = ax + ay;
                xf = total * ax / sum;
                yf = total * ay / sum;
                xs = xd;
                ys = yd;
                case (c.code)
                    CODE_TOP_SHUT:    if (ys > 0) ys = -ys;
                    CODE_RIGHT_SHUT:  if (xs > 0) xs = -xs;
                    CODE_BOTTOM_SHUT: if (ys < 0) ys = -ys;
                    CODE_LEFT_SHUT:   if (xs < 0) xs = -xs;
                    default: ;
                endcase
                case (c.code)
                    CODE_ALL_OPEN, CODE_TOP_SHUT, CODE_RIGHT_SHUT,
                    CODE_BOTTOM_SHUT, CODE_LEFT_SHUT: begin
                        o[xs > 0 ? SIDE_RIGHT : SIDE_LEFT] += xf;
                        o[ys > 0 ? SIDE_TOP : SIDE_BOTTOM] += yf;
                    end
                    CODE_BOTTOM_LEFT: begin
                        o[xd > 0 ? SIDE_BOTTOM : SIDE_LEFT] += xf;
                        o[yd > 0 ? SIDE_LEFT : SIDE_BOTTOM] += yf;
                    end
                    CODE_RIGHT_BOTTOM: begin
                        o[xd < 0 ? SIDE_BOTTOM : SIDE_RIGHT] += xf;
                        o[yd > 0 ? SIDE_RIGHT : SIDE_BOTTOM] += yf;
                    end
                    CODE_TOP_LEFT: begin
                        o[xd > 0 ? SIDE_TOP : SIDE_LEFT] += xf;
                        o[yd < 0 ? SIDE_LEFT : SIDE_TOP] += yf;
                    end
                    CODE_TOP_RIGHT: begin
                        o[xd < 0 ? SIDE_TOP : SIDE_RIGHT] += xf;
                        o[yd < 0 ? SIDE_RIGHT : SIDE_TOP] += yf;
                    end
                    CODE_RIGHT_LEFT: o[(xd + yd) > 0 ? SIDE_RIGHT : SIDE_LEFT] += xf + yf;
                    CODE_TOP_BOTTOM: o[(xd + yd) > 0 ? SIDE_TOP : SIDE_BOTTOM] += xf + yf;
                    CODE_LEFT_ONLY:  o[SIDE_LEFT] += xf + yf;
                    CODE_TOP_ONLY:   o[SIDE_TOP] += xf + yf;
                    CODE_RIGHT_ONLY: o[SIDE_RIGHT] += xf + yf;
                    default:         o[SIDE_BOTTOM] += xf + yf;
                endcase
            end
        end
        r.top = o[SIDE_TOP][OW-1:0];
        r.right = o[SIDE_RIGHT][OW-1:0];
        r.bottom = o[SIDE_BOTTOM][OW-1:0];
        r.left = o[SIDE_LEFT][OW-1:0];
        return r;
    endfunction

    // Random inflow: all ones, zero, full range, or near a shared base so that
    // differences land around the tolerance.
    function automatic logic [IW-1:0] pick_flow(logic [IW-1:0] base);
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2, 3:    return base + IW'($urandom_range(0, 300));
            default: return IW'($urandom);
        endcase
    endfunction

    function automatic t_job cell_job(t_cell c);
        t_job j;
        j = '0;
        j.item = c;
        return j;
    endfunction

    function automatic t_job cfg_job(logic [7:0] tol);
        t_job j;
        j = '0;
        j.is_cfg = 1'b1;
        j.drain = 1'b1;
        j.tol = tol;
        return j;
    endfunction

    // Stimulus: directed corners, then random phases under several tolerances.
    initial begin
        t_cell c;
        t_job j;
        logic [IW-1:0] base;
        logic [7:0] tols[6];
        tols = '{8'd0, 8'd255, 8'd1, 8'd16, 8'd200, 8'd3};
        // every code once: even codes with all-maximum flows (uniform), odd codes with a strong skew
        for (int k = 0; k < 16; k++) begin
            c.code = 4'(k);
            c.top = '1; c.right = '1; c.bottom = '1; c.left = '1;
            if (k % 2) begin
                c.top = '0; c.right = IW'(k * 1000); c.left = '1;
            end
            job_q.push_back(cell_job(c));
        end
        // zero flow, differences exactly at the tolerance, opposite signs
        c = '0;                                                job_q.push_back(cell_job(c));
        c.left = 1; c.code = CODE_ALL_OPEN;                    job_q.push_back(cell_job(c));
        c = '0; c.top = 5; c.right = 3; c.code = CODE_TOP_BOTTOM; job_q.push_back(cell_job(c));
        c = '0; c.right = 7; c.bottom = 7; c.code = CODE_RIGHT_LEFT; job_q.push_back(cell_job(c));
        c = '0; c.left = '1; c.top = '1; c.code = CODE_TOP_RIGHT; job_q.push_back(cell_job(c));
        c = '0; c.right = '1; c.bottom = '1; c.code = CODE_BOTTOM_LEFT; job_q.push_back(cell_job(c));
        for (int p = 0; p < 6; p++) begin
            j = cfg_job(tols[p]);
            job_q.push_back(j);
            for (int k = 0; k < 255; k++) begin
                base = IW'($urandom);
                c.top = pick_flow(base);
                c.right = pick_flow(base);
                c.bottom = pick_flow(base);
                c.left = pick_flow(base);
                c.code = 4'($urandom_range(0, 15));
                j = cell_job(c);
                // one hold-off per phase until everything is back
                j.drain = (k == 100);
                job_q.push_back(j);
            end
        end
        stim_done = 1'b1;
    end

    // Driver: one queue entry at a time with a random gap before each.
    int gap = 0;
    bit active = 1'b0;
    t_job cur;
    always @(posedge i_clk) begin
        bit go_cell;
        bit go_cfg;
        go_cell = 1'b0;
        go_cfg = 1'b0;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_flows.push_back(redistribute(cur.item, model_tol));
                code_hit[cur.item.code] = 1'b1;
                cells_sent++;
                active = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                model_tol = cur.tol;
                cfg_writes++;
                active = 1'b0;
            end
            if (!active && job_q.size() > 0) begin
                cur = job_q.pop_front();
                active = 1'b1;
                gap = $urandom_range(0, 3);
            end
            if (active) begin
                if (gap > 0) begin
                    gap--;
                end else if (cur.drain && expected_flows.size() > 0) begin
                    gap = cur.is_cfg ? LATENCY : 0;   // let the pipeline empty
                end else if (cur.is_cfg) begin
                    go_cfg = 1'b1;
                    cfg_data <= cur.tol;
                end else begin
                    cur.drain = 1'b0;
                    go_cell = 1'b1;
                    inflow_top <= cur.item.top;
                    inflow_right <= cur.item.right;
                    inflow_bottom <= cur.item.bottom;
                    inflow_left <= cur.item.left;
                    open_code <= cur.item.code;
                end
            end
        end
        start <= go_cell;
        cfg_valid <= go_cfg;
    end

    // Monitor: every o_done pulse is one result transaction.
    always @(posedge i_clk) begin
        t_outflow want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (expected_flows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                want = expected_flows.pop_front();
                if (out_top !== want.top || out_right !== want.right ||
                    out_bottom !== want.bottom || out_left !== want.left) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp t=%h r=%h b=%h l=%h got t=%h r=%h b=%h l=%h",
                                 want.top, want.right, want.bottom, want.left,
                                 out_top, out_right, out_bottom, out_left);
                end
            end
        end
    end

    initial begin
        int codes;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while ((job_q.size() > 0 || active || expected_flows.size() > 0)
               && cycles < CYCLE_LIMIT)
            @(posedge i_clk);
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench failed");
        end else begin
            repeat (LATENCY + 4) @(posedge i_clk);
            codes = 0;
            foreach (code_hit[k]) codes += code_hit[k];
            $display("Covered %0d cells over %0d codes, %0d tolerance writes, %0d results.",
                     cells_sent, codes, cfg_writes, results_seen);
            if (mismatches == 0 && expected_flows.size() == 0) begin
                $display("testbench passed");
            end else begin
                $display("%0d mismatches, %0d results outstanding",
                         mismatches, expected_flows.size());
                $display("testbench failed");
            end
        end
        $finish;
    end
endmodule
`default_nettype wire
